// ----- rtl/core/fat12_cte_pkg.sv -----
`timescale 1ns / 1ps

package fat12_cte_pkg;

   localparam int ENTRY_W = 12;
   localparam int LIMIT_W = 13;
   localparam int VALUE_W = 16;
   localparam int STATUS_W = 2;
   localparam int ROW_W = 2 * ENTRY_W;

   localparam logic [ENTRY_W-1:0] ENTRY_MASK = 12'hFFF;
   localparam logic [ENTRY_W-1:0] LOWEST_CLUSTER = 12'd2;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd3072;

   // Command codes on req_cmd. Code 3 is unused and handled by default arms.
   localparam logic [1:0] CMD_READ = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_FIND = 2'd2;

   // Status codes on rsp_status.
   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic load;
      logic clear_step;
      logic scan_next;
      logic wr_en;
      logic rsp_access;
      logic rsp_scan;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic scan_stop;
      logic write_ok;
   } ctl_stat_type;

endpackage

// ----- rtl/core/fat12_cluster_table_engine.sv -----
`timescale 1ns / 1ps

// FAT12 allocation table engine. The table lives in an on-chip RAM of
// (MAX_ENTRIES+1)/2 rows, each row holding the three packed bytes of an
// even/odd entry pair. After reset the block runs a clearing pass that
// writes one row per cycle, so busy stays high until the last row has been
// written and no transaction is taken before then; csr writes are accepted
// during that time. A transaction is accepted on a rising edge with start
// high and busy low. For read, write and the unused command code the row is
// read from the RAM during the accept cycle and checked, returned or merged
// and written back in the next, with busy held high. A find-free scan reads
// one row, that is two entries, per cycle starting at cluster 2, and holds
// busy high until it finds a free entry or has checked the last row below
// the entry limit. Each transaction produces exactly one result, shown on
// rsp_result_value and rsp_status for exactly one cycle with rsp_strobe
// high, in the cycle in which busy drops. The receiver cannot stall this
// output, so it must take every result on the cycle it appears. The entry
// limit register may only be written while no transaction is in progress.

module fat12_cluster_table_engine #(
   parameter int MAX_ENTRIES = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_cmd,
   input  logic [fat12_cte_pkg::ENTRY_W-1:0]    req_cluster,
   input  logic [fat12_cte_pkg::VALUE_W-1:0]    req_value,
   output logic                                 rsp_strobe,
   output logic [fat12_cte_pkg::ENTRY_W-1:0]    rsp_result_value,
   output logic [fat12_cte_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                                 csr_wr_en,
   input  logic [fat12_cte_pkg::LIMIT_W-1:0]    csr_entry_limit
);

   import fat12_cte_pkg::*;

   // Commands from the controller and status back from the datapath.
   ctl_cmd_type  ctl_cmd;
   ctl_stat_type ctl_stat;

   // The controller sequences the clearing pass, single accesses and scans.
   fat12_cte_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .stat    (ctl_stat),
      .cmd     (ctl_cmd),
      .busy    (busy)
   );

   // The datapath owns the table RAM, the limit register and the result
   // registers that drive the response ports.
   fat12_cte_dpath #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_cmd),
      .req_cluster      (req_cluster),
      .req_value        (req_value),
      .csr_wr_en        (csr_wr_en),
      .csr_entry_limit  (csr_entry_limit),
      .cmd              (ctl_cmd),
      .stat             (ctl_stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

endmodule

// ----- rtl/core/fat12_cte_ram.sv -----
`timescale 1ns / 1ps

module fat12_cte_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/fat12_cte_ctrl.sv -----
`timescale 1ns / 1ps

module fat12_cte_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [1:0]                  req_cmd,
   input  fat12_cte_pkg::ctl_stat_type stat,
   output fat12_cte_pkg::ctl_cmd_type  cmd,
   output logic                        busy
);

   import fat12_cte_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_cmd == CMD_FIND) ? ST_SCAN : ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            cmd.rsp_access = 1'b1;
            cmd.wr_en = stat.write_ok;
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (stat.scan_stop) begin
               cmd.rsp_scan = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ----- rtl/core/fat12_cte_dpath.sv -----
`timescale 1ns / 1ps

module fat12_cte_dpath #(
   parameter int MAX_ENTRIES = 4096
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [1:0]                              req_cmd,
   input  logic [fat12_cte_pkg::ENTRY_W-1:0]       req_cluster,
   input  logic [fat12_cte_pkg::VALUE_W-1:0]       req_value,
   input  logic                                    csr_wr_en,
   input  logic [fat12_cte_pkg::LIMIT_W-1:0]       csr_entry_limit,
   input  fat12_cte_pkg::ctl_cmd_type              cmd,
   output fat12_cte_pkg::ctl_stat_type             stat,
   output logic                                    rsp_strobe,
   output logic [fat12_cte_pkg::ENTRY_W-1:0]       rsp_result_value,
   output logic [fat12_cte_pkg::STATUS_W-1:0]      rsp_status
);

   import fat12_cte_pkg::*;

   localparam int ROWS = (MAX_ENTRIES + 1) / 2;
   localparam int RW = $clog2(ROWS);
   localparam logic [LIMIT_W-1:0] CAP = LIMIT_W'(MAX_ENTRIES);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [RW-1:0] FIRST_ROW = RW'(1);

   logic [1:0]          cmd_ff;
   logic [ENTRY_W-1:0]  cluster_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [RW-1:0]       row_ff;
   logic [RW-1:0]       row_in;
   logic                rsp_strobe_ff;
   logic                rsp_strobe_in;
   logic [ENTRY_W-1:0]  rsp_value_ff;
   logic [ENTRY_W-1:0]  rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] rsp_status_in;

   logic [LIMIT_W-1:0]  eff_limit;
   logic                in_range;
   logic [ROW_W-1:0]    rd_data;
   logic [ENTRY_W-1:0]  even_entry;
   logic [ENTRY_W-1:0]  odd_entry;
   logic [ENTRY_W-1:0]  sel_entry;
   logic [ENTRY_W-1:0]  sat_value;
   logic [LIMIT_W-1:0]  row_base;
   logic [LIMIT_W-1:0]  row_odd;
   logic                even_hit;
   logic                odd_hit;
   logic                scan_last;
   logic [RW-1:0]       cluster_row;
   logic                ram_wr_en;
   logic [RW-1:0]       ram_wr_addr;
   logic [ROW_W-1:0]    ram_wr_data;
   logic [RW-1:0]       ram_rd_addr;

   // A row holds three table bytes: the even entry in the low 12 bits and
   // the odd entry in the high 12 bits.
   fat12_cte_ram #(
      .WIDTH(ROW_W),
      .DEPTH(ROWS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_data)
   );

   assign eff_limit = (limit_ff > CAP) ? CAP : limit_ff;
   assign in_range = (cluster_ff >= LOWEST_CLUSTER) && ({1'b0, cluster_ff} < eff_limit);

   assign even_entry = rd_data[ENTRY_W-1:0];
   assign odd_entry = rd_data[ROW_W-1:ENTRY_W];
   assign sel_entry = cluster_ff[0] ? odd_entry : even_entry;
   assign sat_value = (value_ff > VALUE_W'(ENTRY_MASK)) ? ENTRY_MASK : value_ff[ENTRY_W-1:0];
   assign cluster_row = RW'(cluster_ff >> 1);

   assign row_base = LIMIT_W'({row_ff, 1'b0});
   assign row_odd = row_base + LIMIT_W'(1);
   assign even_hit = (row_base < eff_limit) && (even_entry == '0);
   assign odd_hit = (row_odd < eff_limit) && (odd_entry == '0);
   assign scan_last = (row_base + LIMIT_W'(2)) >= eff_limit;

   assign stat.clear_done = (row_ff == LAST_ROW);
   assign stat.scan_stop = even_hit || odd_hit || scan_last;
   assign stat.write_ok = (cmd_ff == CMD_WRITE) && in_range;

   always_comb begin
      ram_wr_en = cmd.clear_step || cmd.wr_en;
      ram_wr_addr = cmd.clear_step ? row_ff : cluster_row;
      if (cmd.clear_step) begin
         ram_wr_data = '0;
      end else if (cluster_ff[0]) begin
         ram_wr_data = {sat_value, even_entry};
      end else begin
         ram_wr_data = {odd_entry, sat_value};
      end

      if (cmd.load) begin
         ram_rd_addr = (req_cmd == CMD_FIND) ? FIRST_ROW : RW'(req_cluster >> 1);
      end else begin
         ram_rd_addr = row_ff + RW'(1);
      end

      row_in = row_ff;
      if (cmd.load) begin
         row_in = FIRST_ROW;
      end else if (cmd.clear_step || cmd.scan_next) begin
         row_in = row_ff + RW'(1);
      end

      rsp_strobe_in = cmd.rsp_access || cmd.rsp_scan;
      rsp_value_in = '0;
      rsp_status_in = STATUS_OK;
      if (cmd.rsp_scan) begin
         if (even_hit) begin
            rsp_value_in = row_base[ENTRY_W-1:0];
         end else if (odd_hit) begin
            rsp_value_in = row_odd[ENTRY_W-1:0];
         end else begin
            rsp_status_in = STATUS_NOFREE;
         end
      end else begin
         case (cmd_ff)
            CMD_READ: begin
               if (in_range) begin
                  rsp_value_in = sel_entry;
               end else begin
                  rsp_status_in = STATUS_RANGE;
               end
            end
            CMD_WRITE: begin
               if (!in_range) begin
                  rsp_status_in = STATUS_RANGE;
               end
            end
            default: begin
               rsp_status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         row_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_entry_limit;
         end
         row_ff <= row_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_cmd;
         cluster_ff <= req_cluster;
         value_ff <= req_value;
      end
      if (rsp_strobe_in) begin
         rsp_value_ff <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ----- rtl/core/fat12_cte_checker.sv -----
`timescale 1ns / 1ps

module fat12_cte_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_strobe,
   input logic [fat12_cte_pkg::ENTRY_W-1:0]    rsp_result_value,
   input logic [fat12_cte_pkg::STATUS_W-1:0]   rsp_status
);

   import fat12_cte_pkg::*;

   // The engine is always busy in the cycle after it accepts a transaction.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("engine not busy after accepting a transaction");

   // A result only follows a cycle in which the engine was working.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a transaction in progress");

   // Every transaction passes through a working state before its result, so results never abut.
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on consecutive cycles");

   // Any failing status carries a zero value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |-> (rsp_result_value == '0))
      else $error("nonzero value with an error status");

endmodule

bind fat12_cluster_table_engine fat12_cte_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_result_value (rsp_result_value),
   .rsp_status       (rsp_status)
);
